FILE: src/rrq_pkg.sv
// rrq_pkg: shared types and fixed field widths of the round robin agent queue
// used by rrq_ctrl, rrq_dp and round_robin_agent_queue_unit
package rrq_pkg;

  localparam int REQ_TYPE_W  = 1;
  localparam int AGENT_W     = 8;
  localparam int TOOL_W      = 8;
  localparam int WORK_W      = 16;
  localparam int STATUS_W    = 2;
  localparam int QLEN_W      = 5;
  localparam int PEND_OUT_W  = 8;
  localparam int ACTIVE_W    = 4;
  localparam int ENTRY_W     = TOOL_W + WORK_W;

  localparam logic REQ_ENQUEUE = 1'b0;
  localparam logic REQ_PICK    = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_FIFO_FULL  = 2'd1,
    ST_TABLE_FULL = 2'd2,
    ST_EMPTY      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_EXEC,
    S_DONE
  } state_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic cap;
    logic look;
    logic exec;
    logic load;
  } cmd_t;

endpackage

FILE: src/rrq_ctrl.sv
// rrq_ctrl: sequencing state machine and output valid register
// depends on rrq_pkg
module rrq_ctrl import rrq_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic out_stall,
  output logic out_valid,
  output cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.look  = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = cmd.load | (out_valid_r & out_stall);
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

FILE: src/rrq_dp.sv
// rrq_dp: order list, per-slot fifo pointers, request memory and result registers
// depends on rrq_pkg, driven by rrq_ctrl commands
module rrq_dp import rrq_pkg::*; #(
  parameter int MAX_AGENTS = 8,
  parameter int FIFO_DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  input  logic [REQ_TYPE_W-1:0] in_req_type,
  input  logic [AGENT_W-1:0]    in_agent_id,
  input  logic [TOOL_W-1:0]     in_tool_id,
  input  logic [WORK_W-1:0]     in_work_handle,
  output logic [STATUS_W-1:0]   out_status,
  output logic [QLEN_W-1:0]     out_queue_length,
  output logic [AGENT_W-1:0]    out_agent_id,
  output logic [TOOL_W-1:0]     out_tool_id,
  output logic [WORK_W-1:0]     out_work_handle,
  output logic [PEND_OUT_W-1:0] out_pending_total,
  output logic [ACTIVE_W-1:0]   out_active_agents
);

  localparam int AW    = $clog2(MAX_AGENTS);
  localparam int CW    = $clog2(MAX_AGENTS + 1);
  localparam int PW    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FW    = $clog2(FIFO_DEPTH + 1);
  localparam int DEPTH = MAX_AGENTS * FIFO_DEPTH;
  localparam int MW    = $clog2(DEPTH);
  localparam int TW    = $clog2(DEPTH + 1);

  // latched request
  logic [REQ_TYPE_W-1:0] req_r;
  logic [AGENT_W-1:0]    agent_r;
  logic [TOOL_W-1:0]     tool_r;
  logic [WORK_W-1:0]     work_r;

  // queue state
  logic [AGENT_W-1:0] order_agent_r [MAX_AGENTS];
  logic [AW-1:0]      order_slot_r  [MAX_AGENTS];
  logic [CW-1:0]      count_r;
  logic [AW-1:0]      rr_r;
  logic [PW-1:0]      head_r [MAX_AGENTS];
  logic [FW-1:0]      fill_r [MAX_AGENTS];
  logic [TW-1:0]      pending_r;
  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rd_data_r;

  // lookup results
  logic [MAX_AGENTS-1:0] match_r, match_nxt;
  logic [AW-1:0]         free_idx_r, free_idx_nxt;

  // result registers
  logic [STATUS_W-1:0]   res_status_r;
  logic [QLEN_W-1:0]     res_qlen_r;
  logic [AGENT_W-1:0]    res_agent_r;
  logic                  res_pick_ok_r;
  logic [PEND_OUT_W-1:0] res_pend_r;
  logic [ACTIVE_W-1:0]   res_active_r;
  logic [STATUS_W-1:0]   o_status_r;
  logic [QLEN_W-1:0]     o_qlen_r;
  logic [AGENT_W-1:0]    o_agent_r;
  logic [TOOL_W-1:0]     o_tool_r;
  logic [WORK_W-1:0]     o_work_r;
  logic [PEND_OUT_W-1:0] o_pend_r;
  logic [ACTIVE_W-1:0]   o_active_r;

  // execute-cycle logic
  logic               enq, hit, table_full, fifo_full, enq_ok, pick_ok, drained;
  logic [AW-1:0]      hit_slot, cur_slot;
  logic [FW-1:0]      cur_fill;
  logic [PW-1:0]      cur_head, eff_head, head_inc;
  logic [FW:0]        pos_sum;
  logic [PW-1:0]      pos;
  logic [MW-1:0]      base, wr_addr, rd_addr;
  logic [CW-1:0]      rr1, cnt_less, rr_wrap;
  logic [CW-1:0]      count_nxt;
  logic [AW-1:0]      rr_nxt;
  logic [TW-1:0]      pending_nxt;
  logic [STATUS_W-1:0] status_nxt;

  always_comb begin
    match_nxt    = '0;
    free_idx_nxt = '0;
    for (int i = 0; i < MAX_AGENTS; i++) begin
      match_nxt[i] = (CW'(i) < count_r) && (order_agent_r[i] == agent_r);
    end
    for (int i = MAX_AGENTS - 1; i >= 0; i--) begin
      if (fill_r[i] == '0) free_idx_nxt = AW'(i);
    end
  end

  always_comb begin
    hit_slot = '0;
    for (int i = 0; i < MAX_AGENTS; i++) begin
      if (match_r[i]) hit_slot = hit_slot | order_slot_r[i];
    end
    enq        = (req_r == REQ_ENQUEUE);
    hit        = |match_r;
    cur_slot   = enq ? (hit ? hit_slot : free_idx_r) : order_slot_r[rr_r];
    cur_fill   = fill_r[cur_slot];
    cur_head   = head_r[cur_slot];
    table_full = !hit && (count_r == CW'(MAX_AGENTS));
    fifo_full  = hit && (cur_fill == FW'(FIFO_DEPTH));
    enq_ok     = enq && !table_full && !fifo_full;
    pick_ok    = !enq && (count_r != '0);
    drained    = (cur_fill == FW'(1));

    // tail position, head plus fill wraps at most once
    eff_head = hit ? cur_head : '0;
    pos_sum  = (FW+1)'(eff_head) + (FW+1)'(cur_fill);
    pos      = (pos_sum >= (FW+1)'(FIFO_DEPTH)) ? PW'(pos_sum - (FW+1)'(FIFO_DEPTH))
                                                 : PW'(pos_sum);
    head_inc = (PW'(cur_head + PW'(1)) == PW'(FIFO_DEPTH) || FIFO_DEPTH == 1) ? '0
                                                 : PW'(cur_head + PW'(1));
    base     = MW'(cur_slot) * MW'(FIFO_DEPTH);
    wr_addr  = base + MW'(pos);
    rd_addr  = base + MW'(cur_head);

    // cursor after a pick, with a drained agent leaving the list
    rr1      = ((CW'(rr_r) + CW'(1)) == count_r) ? '0 : CW'(rr_r) + CW'(1);
    cnt_less = count_r - CW'(1);
    rr_wrap  = (cnt_less == '0) ? '0 : ((rr1 >= cnt_less) ? rr1 - cnt_less : rr1);

    count_nxt   = count_r;
    rr_nxt      = rr_r;
    pending_nxt = pending_r;
    status_nxt  = ST_OK;
    if (enq) begin
      if (table_full)     status_nxt = ST_TABLE_FULL;
      else if (fifo_full) status_nxt = ST_FIFO_FULL;
      if (enq_ok) begin
        pending_nxt = pending_r + TW'(1);
        if (!hit) count_nxt = count_r + CW'(1);
      end
    end else if (pick_ok) begin
      pending_nxt = pending_r - TW'(1);
      if (drained) begin
        count_nxt = cnt_less;
        rr_nxt    = AW'(rr_wrap);
      end else begin
        rr_nxt = AW'(rr1);
      end
    end else begin
      status_nxt = ST_EMPTY;
    end
  end

  // request capture and lookup
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      req_r   <= in_req_type;
      agent_r <= in_agent_id;
      tool_r  <= in_tool_id;
      work_r  <= in_work_handle;
    end
    if (cmd.look) begin
      match_r    <= match_nxt;
      free_idx_r <= free_idx_nxt;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      rr_r      <= '0;
      pending_r <= '0;
      for (int i = 0; i < MAX_AGENTS; i++) begin
        head_r[i] <= '0;
        fill_r[i] <= '0;
      end
    end else if (cmd.exec) begin
      count_r   <= count_nxt;
      rr_r      <= rr_nxt;
      pending_r <= pending_nxt;
      if (enq_ok) begin
        fill_r[cur_slot] <= cur_fill + FW'(1);
        if (!hit) head_r[cur_slot] <= '0;
      end else if (pick_ok) begin
        fill_r[cur_slot] <= cur_fill - FW'(1);
        head_r[cur_slot] <= head_inc;
      end
    end
  end

  // order list, append on a new agent, close the gap when one drains
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (enq_ok && !hit) begin
        order_agent_r[AW'(count_r)] <= agent_r;
        order_slot_r[AW'(count_r)]  <= cur_slot;
      end else if (pick_ok && drained) begin
        for (int i = 0; i < MAX_AGENTS - 1; i++) begin
          if (AW'(i) >= rr_r) begin
            order_agent_r[i] <= order_agent_r[i+1];
            order_slot_r[i]  <= order_slot_r[i+1];
          end
        end
      end
    end
  end

  // request memory
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (enq_ok) mem[wr_addr] <= {tool_r, work_r};
      rd_data_r <= mem[rd_addr];
    end
  end

  // results
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_status_r  <= status_nxt;
      res_qlen_r    <= enq_ok ? QLEN_W'(cur_fill + FW'(1)) : '0;
      res_agent_r   <= pick_ok ? order_agent_r[rr_r] : '0;
      res_pick_ok_r <= pick_ok;
      res_pend_r    <= PEND_OUT_W'(pending_nxt);
      res_active_r  <= ACTIVE_W'(count_nxt);
    end
    if (cmd.load) begin
      o_status_r <= res_status_r;
      o_qlen_r   <= res_qlen_r;
      o_agent_r  <= res_agent_r;
      o_tool_r   <= res_pick_ok_r ? rd_data_r[ENTRY_W-1:WORK_W] : '0;
      o_work_r   <= res_pick_ok_r ? rd_data_r[WORK_W-1:0] : '0;
      o_pend_r   <= res_pend_r;
      o_active_r <= res_active_r;
    end
  end

  assign out_status        = o_status_r;
  assign out_queue_length  = o_qlen_r;
  assign out_agent_id      = o_agent_r;
  assign out_tool_id       = o_tool_r;
  assign out_work_handle   = o_work_r;
  assign out_pending_total = o_pend_r;
  assign out_active_agents = o_active_r;

  a_match_unique: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> $onehot0(match_r)) else $error("agent found at two list places");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_AGENTS)) else $error("order list overflow");
  a_cursor_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (rr_r == '0 && pending_r == '0)) else $error("stale cursor");
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) |-> (CW'(rr_r) < count_r)) else $error("cursor past list end");

endmodule

FILE: src/round_robin_agent_queue_unit.sv
// round_robin_agent_queue_unit: top level of the round robin agent queue
// depends on rrq_pkg, rrq_ctrl and rrq_dp
//
// per-agent request fifos served round robin in agent arrival order. each input
// transfer is an enqueue (agent, tool, work tag) or a pick, and gives exactly one
// result transfer with a status, the new fifo length or the picked request, and
// the pending and active-agent counts. each item passes from input transfer to
// result ready through capture, parallel agent match and free-slot search,
// state update with the request memory access, then the output register load.
// one item is in work at a time; in_stall is low again once the result sits in
// the output register, so the next item enters while the result waits.
// the request memory holds MAX_AGENTS * FIFO_DEPTH entries and needs no clearing
module round_robin_agent_queue_unit import rrq_pkg::*; #(
  parameter int MAX_AGENTS = 8,
  parameter int FIFO_DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [REQ_TYPE_W-1:0] in_req_type,
  input  logic [AGENT_W-1:0]    in_agent_id,
  input  logic [TOOL_W-1:0]     in_tool_id,
  input  logic [WORK_W-1:0]     in_work_handle,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [STATUS_W-1:0]   out_status,
  output logic [QLEN_W-1:0]     out_queue_length,
  output logic [AGENT_W-1:0]    out_agent_id,
  output logic [TOOL_W-1:0]     out_tool_id,
  output logic [WORK_W-1:0]     out_work_handle,
  output logic [PEND_OUT_W-1:0] out_pending_total,
  output logic [ACTIVE_W-1:0]   out_active_agents
);

  cmd_t cmd;

  // sequencer: one step per cycle, waits in the last step on a held result
  rrq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // queue state, request memory and result registers
  rrq_dp #(
    .MAX_AGENTS (MAX_AGENTS),
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_req_type       (in_req_type),
    .in_agent_id       (in_agent_id),
    .in_tool_id        (in_tool_id),
    .in_work_handle    (in_work_handle),
    .out_status        (out_status),
    .out_queue_length  (out_queue_length),
    .out_agent_id      (out_agent_id),
    .out_tool_id       (out_tool_id),
    .out_work_handle   (out_work_handle),
    .out_pending_total (out_pending_total),
    .out_active_agents (out_active_agents)
  );

endmodule
